@@ hw/rtl/rsz_pkg.sv @@
// Shared types and constants for the bilinear RGBA resizer.
// No dependencies; used by every module under hw/rtl.
package rsz_pkg;

   // Request and result field widths.
   localparam int COORD_W     = 12;
   localparam int PIX_W       = 32;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHAN    = 4;
   localparam int REQ_TDATA_W = 56;   // col, row, pixel_in
   localparam int RSP_TDATA_W = 32;   // pixel_out

   // Size register widths.
   localparam int SRC_SIZE_W = 12;
   localparam int DST_SIZE_W = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;

   // Default sizing of the design.
   localparam int SRC_MAX_WIDTH_DEF  = 2048;
   localparam int SRC_MAX_HEIGHT_DEF = 2048;
   localparam int DST_MAX_DEF        = 4096;
   localparam int FRAC_BITS_DEF      = 8;

   // Register values after reset.
   localparam logic [SRC_SIZE_W-1:0] SRC_WIDTH_RST  = 12'd1;
   localparam logic [SRC_SIZE_W-1:0] SRC_HEIGHT_RST = 12'd1;
   localparam logic [DST_SIZE_W-1:0] DST_WIDTH_RST  = 13'd1664;
   localparam logic [DST_SIZE_W-1:0] DST_HEIGHT_RST = 13'd936;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_idx_type;

   // Request kinds carried in tuser.
   localparam logic OP_STORE   = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   // Result status carried in tuser.
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

endpackage

@@ hw/rtl/rsz_axis.sv @@
// One axis lane: source index, neighbor index and fraction for a target coordinate.
// Depends on rsz_pkg. A restoring divider produces one quotient bit per cycle.
module rsz_axis #(
   parameter int SRC_MAX   = rsz_pkg::SRC_MAX_WIDTH_DEF,
   parameter int DST_MAX   = rsz_pkg::DST_MAX_DEF,
   parameter int FRAC_BITS = rsz_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [rsz_pkg::COORD_W-1:0]      coord,
   input  logic [$clog2(SRC_MAX+1)-1:0]     src,
   input  logic [$clog2(DST_MAX+1)-1:0]     dst,
   output logic                             done,
   output logic [$clog2(SRC_MAX)-1:0]       idx0,
   output logic [$clog2(SRC_MAX)-1:0]       idx1,
   output logic [FRAC_BITS-1:0]             frac
);

   localparam int SW   = $clog2(SRC_MAX+1);
   localparam int DW   = $clog2(DST_MAX+1);
   localparam int IW   = $clog2(SRC_MAX);
   localparam int QW   = IW + FRAC_BITS;
   localparam int PW   = rsz_pkg::COORD_W + 1 + SW;
   localparam int NW   = PW + 1;
   localparam int DENW = DW + 1;
   localparam int RW   = DENW + 1;
   localparam int CW   = $clog2(QW);

   typedef enum logic [3:0] {
      L_IDLE = 4'b0001,
      L_PREP = 4'b0010,
      L_DIV  = 4'b0100,
      L_DONE = 4'b1000
   } lane_state_type;

   lane_state_type   state_ff, state_in;
   logic [PW-1:0]    prod_ff, prod_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    lo_ff, lo_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   logic [NW-1:0]    num;
   logic [PW-1:0]    num_pos;
   logic [RW-1:0]    den;
   logic [RW-1:0]    trial;
   logic             trial_ge;
   logic [SW-1:0]    next_idx;

   // Numerator (2t+1)*src - dst; the sign bit marks the left border case.
   assign num      = {1'b0, prod_ff} - NW'(dst);
   assign num_pos  = num[NW-2:0];
   assign den      = RW'({dst, 1'b0});
   assign trial    = {rem_ff[RW-2:0], lo_ff[QW-1]};
   assign trial_ge = (trial >= den);

   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      lo_in    = lo_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      if (start) begin
         prod_in  = PW'({coord, 1'b1}) * PW'(src);
         state_in = L_PREP;
      end else begin
         unique case (state_ff)
            L_IDLE: ;
            L_PREP: begin
               q_in = '0;
               if (num[NW-1]) begin
                  state_in = L_DONE;
               end else begin
                  // The quotient of num*2^FRAC_BITS by 2*dst fits in QW bits.
                  rem_in   = RW'(num_pos >> IW);
                  lo_in    = {num_pos[IW-1:0], {FRAC_BITS{1'b0}}};
                  cnt_in   = CW'(QW - 1);
                  state_in = L_DIV;
               end
            end
            L_DIV: begin
               rem_in = trial_ge ? (trial - den) : trial;
               lo_in  = {lo_ff[QW-2:0], 1'b0};
               q_in   = {q_ff[QW-2:0], trial_ge};
               cnt_in = cnt_ff - CW'(1);
               if (cnt_ff == '0) begin
                  state_in = L_DONE;
               end
            end
            L_DONE: ;
            default: state_in = L_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
      end else begin
         state_ff <= state_in;
      end
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      lo_ff   <= lo_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
   end

   // Upper quotient bits are the index, lower bits the fraction.
   assign idx0     = q_ff[QW-1:FRAC_BITS];
   assign frac     = q_ff[FRAC_BITS-1:0];
   assign next_idx = SW'(idx0) + SW'(1);
   assign idx1     = (next_idx < src) ? next_idx[IW-1:0] : idx0;
   assign done     = (state_ff == L_DONE);

endmodule

@@ hw/rtl/rsz_blend.sv @@
// One channel lane: two-stage bilinear blend of four 8-bit samples.
// Depends on rsz_pkg for the channel width.
module rsz_blend #(
   parameter int FRAC_BITS = rsz_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic [rsz_pkg::CHAN_W-1:0]  p00,
   input  logic [rsz_pkg::CHAN_W-1:0]  p01,
   input  logic [rsz_pkg::CHAN_W-1:0]  p10,
   input  logic [rsz_pkg::CHAN_W-1:0]  p11,
   input  logic [FRAC_BITS-1:0]        fx,
   input  logic [FRAC_BITS-1:0]        fy,
   output logic [rsz_pkg::CHAN_W-1:0]  chan
);

   localparam int WW   = FRAC_BITS + 1;
   localparam int TW   = rsz_pkg::CHAN_W + FRAC_BITS + 1;
   localparam int SUMW = rsz_pkg::CHAN_W + 2 * FRAC_BITS + 1;
   localparam logic [WW-1:0]   ONE  = WW'(1) << FRAC_BITS;
   localparam logic [SUMW-1:0] HALF = SUMW'(1) << (2 * FRAC_BITS - 1);
   localparam logic [SUMW-1:0] CHAN_MAX = SUMW'({rsz_pkg::CHAN_W{1'b1}});

   logic [TW-1:0]               top_ff, top_in, bot_ff, bot_in;
   logic [rsz_pkg::CHAN_W-1:0]  chan_ff, chan_in;
   logic [WW-1:0]               wx0, wx1, wy0, wy1;
   logic [SUMW-1:0]             sum, rounded;

   assign wx1 = WW'(fx);
   assign wx0 = ONE - wx1;
   assign wy1 = WW'(fy);
   assign wy0 = ONE - wy1;

   // First stage blends along the row, second along the column.
   assign top_in  = TW'(p00) * TW'(wx0) + TW'(p01) * TW'(wx1);
   assign bot_in  = TW'(p10) * TW'(wx0) + TW'(p11) * TW'(wx1);
   assign sum     = SUMW'(top_ff) * SUMW'(wy0) + SUMW'(bot_ff) * SUMW'(wy1);
   assign rounded = (sum + HALF) >> (2 * FRAC_BITS);
   assign chan_in = (rounded > CHAN_MAX) ? {rsz_pkg::CHAN_W{1'b1}}
                                         : rounded[rsz_pkg::CHAN_W-1:0];

   always_ff @(posedge clock) begin
      top_ff  <= top_in;
      bot_ff  <= bot_in;
      chan_ff <= chan_in;
   end

   assign chan = chan_ff;

endmodule

@@ hw/rtl/bilinear_rgba_resize_top.sv @@
// Top level of the bilinear RGBA resizer: frame store, sequencer and result merge.
// Depends on rsz_pkg, rsz_axis and rsz_blend.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   req     | in        | req_tvalid/tready  | tuser opcode; tdata col, row, pixel_in
//   rsp     | out       | rsp_tvalid/tready  | tuser status; tdata pixel_out
//   csr     | in        | csr_we             | csr_index, csr_wdata (no read-back)
//
// A store request is written into the frame store at the edge where it is accepted,
// if its coordinate lies inside the store, and the block is ready again in the next cycle.
// A compute request runs the two axis lanes side by side, each with a one-bit-per-cycle
// divider; the four neighbor fetches then use the single read port of the frame store,
// one per cycle, and the channel lanes add two stages. A target coordinate outside the
// configured target size skips the lanes and goes straight to the done state, where it
// is answered with status set and a zero pixel.
// Reset is synchronous and active high. It clears the sequencer, the axis lanes and
// the result valid flag and presets the size registers; the frame store is not cleared.
// The result sits in an output register, so a new request is taken while an
// earlier result waits; a compute only stalls at its end if that register is full.
module bilinear_rgba_resize_top #(
   parameter int SRC_MAX_WIDTH  = rsz_pkg::SRC_MAX_WIDTH_DEF,
   parameter int SRC_MAX_HEIGHT = rsz_pkg::SRC_MAX_HEIGHT_DEF,
   parameter int DST_MAX        = rsz_pkg::DST_MAX_DEF,
   parameter int FRAC_BITS      = rsz_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [rsz_pkg::REQ_TDATA_W-1:0]    req_tdata,  // col[11:0], row[23:12], pixel_in[55:24]
   input  logic                               req_tuser,  // opcode[0]
   // Result channel.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [rsz_pkg::RSP_TDATA_W-1:0]    rsp_tdata,  // pixel_out[31:0]
   output logic                               rsp_tuser,  // status[0]
   // Configuration port.
   input  logic                               csr_we,
   input  logic [rsz_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rsz_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SWX   = $clog2(SRC_MAX_WIDTH + 1);
   localparam int SHX   = $clog2(SRC_MAX_HEIGHT + 1);
   localparam int DW    = $clog2(DST_MAX + 1);
   localparam int XIW   = $clog2(SRC_MAX_WIDTH);
   localparam int YIW   = $clog2(SRC_MAX_HEIGHT);
   localparam int DEPTH = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [AW-1:0] STRIDE = AW'(SRC_MAX_WIDTH);

   // Sequencer states.
   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_AXIS    = 6'b000010,
      S_FETCH   = 6'b000100,
      S_BLEND_A = 6'b001000,
      S_BLEND_B = 6'b010000,
      S_DONE    = 6'b100000
   } seq_state_type;

   // Request fields.
   logic                          req_op;
   logic [rsz_pkg::COORD_W-1:0]   req_col, req_row;
   logic [rsz_pkg::PIX_W-1:0]     req_pixel;

   assign req_op    = req_tuser;
   assign req_col   = req_tdata[11:0];
   assign req_row   = req_tdata[23:12];
   assign req_pixel = req_tdata[55:24];

   // Size registers and their saturated views.
   logic [rsz_pkg::SRC_SIZE_W-1:0] src_w_ff, src_w_in, src_h_ff, src_h_in;
   logic [rsz_pkg::DST_SIZE_W-1:0] dst_w_ff, dst_w_in, dst_h_ff, dst_h_in;
   logic [SWX-1:0]                 src_w_sat;
   logic [SHX-1:0]                 src_h_sat;
   logic [DW-1:0]                  dst_w_sat, dst_h_sat;

   always_comb begin
      src_w_in = src_w_ff;
      src_h_in = src_h_ff;
      dst_w_in = dst_w_ff;
      dst_h_in = dst_h_ff;
      if (csr_we) begin
         unique case (rsz_pkg::csr_idx_type'(csr_index))
            rsz_pkg::CSR_SRC_WIDTH:  src_w_in = csr_wdata[rsz_pkg::SRC_SIZE_W-1:0];
            rsz_pkg::CSR_SRC_HEIGHT: src_h_in = csr_wdata[rsz_pkg::SRC_SIZE_W-1:0];
            rsz_pkg::CSR_DST_WIDTH:  dst_w_in = csr_wdata;
            rsz_pkg::CSR_DST_HEIGHT: dst_h_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= rsz_pkg::SRC_WIDTH_RST;
         src_h_ff <= rsz_pkg::SRC_HEIGHT_RST;
         dst_w_ff <= rsz_pkg::DST_WIDTH_RST;
         dst_h_ff <= rsz_pkg::DST_HEIGHT_RST;
      end else begin
         src_w_ff <= src_w_in;
         src_h_ff <= src_h_in;
         dst_w_ff <= dst_w_in;
         dst_h_ff <= dst_h_in;
      end
   end

   // Sizes are used saturated to 1 up to the design maximum.
   always_comb begin
      if (src_w_ff == '0)                   src_w_sat = SWX'(1);
      else if (32'(src_w_ff) > SRC_MAX_WIDTH) src_w_sat = SWX'(SRC_MAX_WIDTH);
      else                                  src_w_sat = SWX'(src_w_ff);
      if (src_h_ff == '0)                    src_h_sat = SHX'(1);
      else if (32'(src_h_ff) > SRC_MAX_HEIGHT) src_h_sat = SHX'(SRC_MAX_HEIGHT);
      else                                   src_h_sat = SHX'(src_h_ff);
      if (dst_w_ff == '0)             dst_w_sat = DW'(1);
      else if (32'(dst_w_ff) > DST_MAX) dst_w_sat = DW'(DST_MAX);
      else                            dst_w_sat = DW'(dst_w_ff);
      if (dst_h_ff == '0)             dst_h_sat = DW'(1);
      else if (32'(dst_h_ff) > DST_MAX) dst_h_sat = DW'(DST_MAX);
      else                            dst_h_sat = DW'(dst_h_ff);
   end

   // Sequencer registers.
   seq_state_type             state_ff, state_in;
   logic [2:0]                fetch_cnt_ff, fetch_cnt_in;
   logic                      err_ff, err_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [rsz_pkg::PIX_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic                      rsp_status_ff, rsp_status_in;

   logic req_accept, store_accept, compute_accept, range_err, lane_start;
   logic rsp_load;

   assign req_tready     = (state_ff == S_IDLE);
   assign req_accept     = req_tvalid && req_tready;
   assign store_accept   = req_accept && (req_op == rsz_pkg::OP_STORE);
   assign compute_accept = req_accept && (req_op == rsz_pkg::OP_COMPUTE);
   assign range_err      = (32'(req_col) >= 32'(dst_w_sat)) ||
                           (32'(req_row) >= 32'(dst_h_sat));
   assign lane_start     = compute_accept && !range_err;
   assign rsp_load       = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   // Axis lanes: column and row are resolved side by side.
   logic                 x_done, y_done;
   logic [XIW-1:0]       x0, x1;
   logic [YIW-1:0]       y0, y1;
   logic [FRAC_BITS-1:0] fx, fy;

   rsz_axis #(
      .SRC_MAX   (SRC_MAX_WIDTH),
      .DST_MAX   (DST_MAX),
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_x (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .coord (req_col),
      .src   (src_w_sat),
      .dst   (dst_w_sat),
      .done  (x_done),
      .idx0  (x0),
      .idx1  (x1),
      .frac  (fx)
   );

   rsz_axis #(
      .SRC_MAX   (SRC_MAX_HEIGHT),
      .DST_MAX   (DST_MAX),
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_y (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .coord (req_row),
      .src   (src_h_sat),
      .dst   (dst_h_sat),
      .done  (y_done),
      .idx0  (y0),
      .idx1  (y1),
      .frac  (fy)
   );

   // Frame store: one write port for stores, one registered read port for fetches.
   logic [rsz_pkg::PIX_W-1:0] frame_mem [DEPTH];
   logic [rsz_pkg::PIX_W-1:0] rd_data_ff;
   logic [AW-1:0]             wr_addr, rd_addr;
   logic                      wr_en;
   logic [XIW-1:0]            fetch_x;
   logic [YIW-1:0]            fetch_y;

   assign wr_en   = store_accept && (32'(req_col) < SRC_MAX_WIDTH) &&
                    (32'(req_row) < SRC_MAX_HEIGHT);
   assign wr_addr = AW'(req_row) * STRIDE + AW'(req_col);

   // Fetch order: bit 0 of the counter picks the column neighbor, bit 1 the row.
   assign fetch_x = fetch_cnt_ff[0] ? x1 : x0;
   assign fetch_y = fetch_cnt_ff[1] ? y1 : y0;
   assign rd_addr = AW'(fetch_y) * STRIDE + AW'(fetch_x);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= req_pixel;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= frame_mem[rd_addr];
   end

   // Neighbor pixels in the order top-left, top-right, bottom-left, bottom-right.
   logic [rsz_pkg::PIX_W-1:0] pix_ff [4];
   logic [1:0]                cap_idx;
   logic                      cap_en;

   assign cap_idx = 2'(fetch_cnt_ff - 3'd1);
   assign cap_en  = (state_ff == S_FETCH) && (fetch_cnt_ff != 3'd0);

   always_ff @(posedge clock) begin
      if (cap_en) begin
         pix_ff[cap_idx] <= rd_data_ff;
      end
   end

   // Channel lanes, then the merge that packs the four channels.
   logic [rsz_pkg::CHAN_W-1:0] chan [rsz_pkg::NUM_CHAN];
   logic [rsz_pkg::PIX_W-1:0]  merged;

   for (genvar c = 0; c < rsz_pkg::NUM_CHAN; c++) begin : g_chan
      rsz_blend #(
         .FRAC_BITS (FRAC_BITS)
      ) u_blend (
         .clock (clock),
         .p00   (pix_ff[0][c*rsz_pkg::CHAN_W +: rsz_pkg::CHAN_W]),
         .p01   (pix_ff[1][c*rsz_pkg::CHAN_W +: rsz_pkg::CHAN_W]),
         .p10   (pix_ff[2][c*rsz_pkg::CHAN_W +: rsz_pkg::CHAN_W]),
         .p11   (pix_ff[3][c*rsz_pkg::CHAN_W +: rsz_pkg::CHAN_W]),
         .fx    (fx),
         .fy    (fy),
         .chan  (chan[c])
      );
      assign merged[c*rsz_pkg::CHAN_W +: rsz_pkg::CHAN_W] = chan[c];
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      fetch_cnt_in = fetch_cnt_ff;
      err_in       = err_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (compute_accept) begin
               err_in   = range_err;
               state_in = range_err ? S_DONE : S_AXIS;
            end
         end
         S_AXIS: begin
            fetch_cnt_in = 3'd0;
            if (x_done && y_done) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            fetch_cnt_in = fetch_cnt_ff + 3'd1;
            if (fetch_cnt_ff == 3'd4) begin
               state_in = S_BLEND_A;
            end
         end
         S_BLEND_A: state_in = S_BLEND_B;
         S_BLEND_B: state_in = S_DONE;
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Output register; an errored request returns a zero pixel.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_pixel_in  = err_ff ? '0 : merged;
         rsp_status_in = err_ff ? rsz_pkg::STATUS_RANGE : rsz_pkg::STATUS_OK;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fetch_cnt_ff <= 3'd0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fetch_cnt_ff <= fetch_cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pixel_ff;
   assign rsp_tuser  = rsp_status_ff;

   // The fetch counter never runs past the capture of the fourth neighbor.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |-> (fetch_cnt_ff <= 3'd4))
      else $error("fetch counter overran");

   // An out-of-range compute skips the lanes and is answered with an error.
   assert property (@(posedge clock) disable iff (reset)
      (compute_accept && range_err) |=> (state_ff == S_DONE) && err_ff)
      else $error("range error not routed to result");

   // An error result always carries a zero pixel.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == rsz_pkg::STATUS_RANGE)) |-> (rsp_tdata == '0))
      else $error("error result with nonzero pixel");

   // A store never leaves the sequencer busy.
   assert property (@(posedge clock) disable iff (reset)
      store_accept |=> (state_ff == S_IDLE))
      else $error("store left the sequencer busy");

endmodule
